>>> design/stepper_pulse_generator_unit_assert.svh
// Assertion macros used by the stepper pulse generator controller
`ifndef STEPPER_PULSE_GENERATOR_UNIT_ASSERT_SVH
`define STEPPER_PULSE_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SPG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spg assertion failed");

// next-cycle implication, disabled during reset
`define SPG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spg assertion failed");

`endif

>>> design/spg_pkg.sv
// Shared constants, codes and types of the stepper pulse generator
package spg_pkg;

    localparam int MOTOR_COUNT = 4;
    localparam int MIDX_W      = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam int LANE_BITS   = 4;

    localparam int KIND_W      = 3;
    localparam int MOTOR_W     = 3;
    localparam int VALUE_W     = 32;
    localparam int ERR_W       = 2;
    localparam int SPEED_W     = 20;
    localparam int PERIOD_W    = 28;
    localparam int PULSE_W     = 23;
    localparam int POS_W       = 32;
    localparam int ANGLE_W     = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 28;

    localparam int DIVIDEND_W  = PERIOD_W;
    localparam int DIVISOR_W   = SPEED_W;
    localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);

    localparam logic [PULSE_W-1:0] ANGLE_SCALE = PULSE_W'(100);

    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SPEED  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DIR    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ENABLE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MOVE   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_STATUS = 3'd5;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_MOTOR = 2'd1;
    localparam logic [ERR_W-1:0] ERR_PARAM = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_COUNTER_FREQ = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_SPEED    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_SPEED    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_ANGLE   = 2'd3;

    localparam logic [PERIOD_W-1:0] RST_COUNTER_FREQ = 28'd1000000;
    localparam logic [SPEED_W-1:0]  RST_MIN_SPEED    = 20'd1;
    localparam logic [SPEED_W-1:0]  RST_MAX_SPEED    = 20'd1000;
    localparam logic [ANGLE_W-1:0]  RST_STEP_ANGLE   = 16'd180;

    typedef struct packed {
        logic accept_single;
        logic div_start;
        logic div_apply;
        logic out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_ctrl_status;

    typedef struct packed {
        logic [ERR_W-1:0]       error;
        logic                   enabled;
        logic                   direction;
        logic [SPEED_W-1:0]     speed_now;
        logic [PULSE_W-1:0]     pulses_left;
        logic signed [POS_W-1:0] position;
        logic [LANE_BITS-1:0]   step_levels;
        logic [LANE_BITS-1:0]   finished;
    } t_result;

endpackage

>>> design/spg_in_if.sv
// Command input channel of the stepper pulse generator
interface spg_in_if;
    logic                            valid;
    logic                            ready;
    logic [spg_pkg::KIND_W-1:0]      kind;
    logic [spg_pkg::MOTOR_W-1:0]     motor;
    logic [spg_pkg::VALUE_W-1:0]     value;

    modport source (output valid, output kind, output motor, output value, input ready);
    modport sink   (input valid, input kind, input motor, input value, output ready);
endinterface

>>> design/spg_out_if.sv
// Result output channel of the stepper pulse generator
interface spg_out_if;
    logic                              valid;
    logic                              ready;
    logic [spg_pkg::ERR_W-1:0]         error;
    logic                              enabled;
    logic                              direction;
    logic [spg_pkg::SPEED_W-1:0]       speed_now;
    logic [spg_pkg::PULSE_W-1:0]       pulses_left;
    logic signed [spg_pkg::POS_W-1:0]  position;
    logic [spg_pkg::LANE_BITS-1:0]     step_levels;
    logic [spg_pkg::LANE_BITS-1:0]     finished;

    modport source (output valid, output error, output enabled, output direction,
                    output speed_now, output pulses_left, output position,
                    output step_levels, output finished, input ready);
    modport sink   (input valid, input error, input enabled, input direction,
                    input speed_now, input pulses_left, input position,
                    input step_levels, input finished, output ready);
endinterface

>>> design/spg_divider.sv
// Restoring divider, one quotient bit per cycle
module spg_divider (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [spg_pkg::DIVIDEND_W-1:0]     i_dividend,
    input  logic [spg_pkg::DIVISOR_W-1:0]      i_divisor,
    output logic [spg_pkg::DIVIDEND_W-1:0]     o_quotient,
    output logic                               o_done
);

    logic [spg_pkg::DIVISOR_W-1:0]   r_rem;
    logic [spg_pkg::DIVISOR_W-1:0]   r_den;
    logic [spg_pkg::DIVIDEND_W-1:0]  r_quo;
    logic [spg_pkg::DIV_CNT_W-1:0]   r_cnt;

    logic [spg_pkg::DIVISOR_W:0]     rem_sh;
    logic [spg_pkg::DIVISOR_W:0]     diff;
    logic                            ge;
    logic [spg_pkg::DIVISOR_W-1:0]   n_rem;

    always_comb begin
        rem_sh = {r_rem, r_quo[spg_pkg::DIVIDEND_W-1]};
        diff   = rem_sh - {1'b0, r_den};
        ge     = (rem_sh >= {1'b0, r_den});
        n_rem  = ge ? diff[spg_pkg::DIVISOR_W-1:0] : rem_sh[spg_pkg::DIVISOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= spg_pkg::DIV_CNT_W'(spg_pkg::DIVIDEND_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - spg_pkg::DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[spg_pkg::DIVIDEND_W-2:0], ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = (r_cnt == '0);

endmodule

>>> design/spg_ctrl.sv
// Controller: input acceptance, divide sequencing, output register valid
`include "stepper_pulse_generator_unit_assert.svh"

module spg_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  spg_pkg::t_ctrl_status i_status,
    output spg_pkg::t_ctrl_cmd    o_cmd
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_DIV
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;
    logic   accept;

    always_comb begin
        out_free            = !r_out_valid || i_out_ready;
        o_in_ready          = (r_state == S_IDLE) && out_free;
        accept              = i_in_valid && o_in_ready;
        o_cmd.accept_single = accept && !i_status.need_div;
        o_cmd.div_start     = accept && i_status.need_div;
        o_cmd.div_apply     = (r_state == S_DIV) && i_status.div_done && out_free;
        o_cmd.out_load      = o_cmd.accept_single || o_cmd.div_apply;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.div_start) r_state <= S_DIV;
                end
                S_DIV: begin
                    if (o_cmd.div_apply) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    `SPG_ASSERT_IMP(a_load_free, i_clk, i_rst_n, o_cmd.out_load, !r_out_valid || i_out_ready)
    `SPG_ASSERT_NXT(a_load_valid, i_clk, i_rst_n, o_cmd.out_load, r_out_valid)
    `SPG_ASSERT_NXT(a_div_enter, i_clk, i_rst_n, o_cmd.div_start, r_state == S_DIV)
    `SPG_ASSERT_IMP(a_apply_done, i_clk, i_rst_n, o_cmd.div_apply, i_status.div_done)

endmodule

>>> design/spg_datapath.sv
// Datapath: config registers, per-motor state, divider and result register
module spg_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [spg_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [spg_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [spg_pkg::KIND_W-1:0]          i_kind,
    input  logic [spg_pkg::MOTOR_W-1:0]         i_motor,
    input  logic [spg_pkg::VALUE_W-1:0]         i_value,
    input  spg_pkg::t_ctrl_cmd                  i_cmd,
    output spg_pkg::t_ctrl_status               o_status,
    output spg_pkg::t_result                    o_result
);

    localparam int MC         = spg_pkg::MOTOR_COUNT;
    localparam int MIDX_LOCAL = spg_pkg::MIDX_W;

    logic [spg_pkg::PERIOD_W-1:0] r_counter_freq;
    logic [spg_pkg::SPEED_W-1:0]  r_min_speed;
    logic [spg_pkg::SPEED_W-1:0]  r_max_speed;
    logic [spg_pkg::ANGLE_W-1:0]  r_step_angle;

    logic                          r_enable  [MC];
    logic                          r_dir     [MC];
    logic [spg_pkg::SPEED_W-1:0]   r_speed   [MC];
    logic [spg_pkg::PERIOD_W-1:0]  r_reload  [MC];
    logic [spg_pkg::PERIOD_W-1:0]  r_half    [MC];
    logic [spg_pkg::PERIOD_W-1:0]  r_counter [MC];
    logic [spg_pkg::PULSE_W-1:0]   r_remain  [MC];
    logic [spg_pkg::POS_W-1:0]     r_pos     [MC];
    logic [spg_pkg::ERR_W-1:0]     r_err     [MC];

    logic                          n_enable  [MC];
    logic                          n_dir     [MC];
    logic [spg_pkg::SPEED_W-1:0]   n_speed   [MC];
    logic [spg_pkg::PERIOD_W-1:0]  n_reload  [MC];
    logic [spg_pkg::PERIOD_W-1:0]  n_half    [MC];
    logic [spg_pkg::PERIOD_W-1:0]  n_counter [MC];
    logic [spg_pkg::PULSE_W-1:0]   n_remain  [MC];
    logic [spg_pkg::POS_W-1:0]     n_pos     [MC];
    logic [spg_pkg::ERR_W-1:0]     n_err     [MC];

    logic                          r_op_is_move;
    logic [spg_pkg::MOTOR_W-1:0]   r_op_motor;
    logic [spg_pkg::SPEED_W-1:0]   r_op_speed;

    spg_pkg::t_result              r_out;
    spg_pkg::t_result              result;

    logic                          in_valid_motor;
    logic                          speed_ok;
    logic                          angle_ok;
    logic [spg_pkg::PULSE_W-1:0]   angle_mul;
    logic                          in_is_move;
    logic [spg_pkg::DIVIDEND_W-1:0] div_dividend;
    logic [spg_pkg::DIVISOR_W-1:0] div_divisor;
    logic [spg_pkg::DIVIDEND_W-1:0] quotient;
    logic                          div_done;

    logic [spg_pkg::MOTOR_W-1:0]   a_motor;
    logic                          a_valid;
    logic [MIDX_LOCAL-1:0]         a_idx;
    logic [spg_pkg::ERR_W-1:0]     err;
    logic [MC-1:0]                 fin_all;
    logic [MC-1:0]                 lvl_all;

    // command classification for the controller
    always_comb begin
        in_valid_motor = ({1'b0, i_motor} < (spg_pkg::MOTOR_W + 1)'(MC));
        speed_ok   = (i_value != '0)
                  && (i_value >= {12'b0, r_min_speed})
                  && (i_value <= {12'b0, r_max_speed});
        angle_ok   = (i_value[31:16] == '0) && (r_step_angle != '0);
        in_is_move = (i_kind == spg_pkg::KIND_MOVE);
        o_status.need_div = in_valid_motor
                         && (((i_kind == spg_pkg::KIND_SPEED) && speed_ok)
                          || (in_is_move && angle_ok));
        o_status.div_done = div_done;
        angle_mul    = spg_pkg::PULSE_W'(i_value[15:0]) * spg_pkg::ANGLE_SCALE;
        div_dividend = in_is_move ? spg_pkg::DIVIDEND_W'(angle_mul) : r_counter_freq;
        div_divisor  = in_is_move ? spg_pkg::DIVISOR_W'(r_step_angle)
                                  : i_value[spg_pkg::SPEED_W-1:0];
    end

    spg_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (quotient),
        .o_done     (div_done)
    );

    // next state of all motors and the result of the current transfer
    always_comb begin
        n_enable  = r_enable;
        n_dir     = r_dir;
        n_speed   = r_speed;
        n_reload  = r_reload;
        n_half    = r_half;
        n_counter = r_counter;
        n_remain  = r_remain;
        n_pos     = r_pos;
        n_err     = r_err;
        err       = spg_pkg::ERR_OK;
        fin_all   = '0;

        a_motor = i_cmd.div_apply ? r_op_motor : i_motor;
        a_valid = ({1'b0, a_motor} < (spg_pkg::MOTOR_W + 1)'(MC));
        a_idx   = a_motor[MIDX_LOCAL-1:0];

        if (i_cmd.accept_single) begin
            if (i_kind == spg_pkg::KIND_TICK) begin
                for (int m = 0; m < MC; m++) begin
                    if (r_enable[m] && (r_speed[m] != '0)) begin
                        if (r_counter[m] >= r_reload[m]) begin
                            n_counter[m] = '0;
                            n_pos[m] = r_dir[m] ? (r_pos[m] - spg_pkg::POS_W'(1))
                                                : (r_pos[m] + spg_pkg::POS_W'(1));
                            if (r_remain[m] != '0) begin
                                n_remain[m] = r_remain[m] - spg_pkg::PULSE_W'(1);
                                if (r_remain[m] == spg_pkg::PULSE_W'(1)) begin
                                    n_enable[m] = 1'b0;
                                    fin_all[m]  = 1'b1;
                                end
                            end
                        end else begin
                            n_counter[m] = r_counter[m] + spg_pkg::PERIOD_W'(1);
                        end
                    end
                end
            end else if (!(i_kind inside {[spg_pkg::KIND_SPEED:spg_pkg::KIND_STATUS]})) begin
                err = spg_pkg::ERR_PARAM;
            end else if (!a_valid) begin
                err = spg_pkg::ERR_MOTOR;
            end else begin
                case (i_kind)
                    spg_pkg::KIND_SPEED: begin
                        if (i_value == '0) begin
                            n_enable[a_idx]  = 1'b0;
                            n_counter[a_idx] = '0;
                            n_speed[a_idx]   = '0;
                            n_reload[a_idx]  = '0;
                            n_half[a_idx]    = '0;
                        end else begin
                            n_err[a_idx] = spg_pkg::ERR_PARAM;
                            err          = spg_pkg::ERR_PARAM;
                        end
                    end
                    spg_pkg::KIND_DIR: begin
                        if (i_value[31:1] != '0) begin
                            n_err[a_idx] = spg_pkg::ERR_PARAM;
                            err          = spg_pkg::ERR_PARAM;
                        end else begin
                            n_dir[a_idx] = i_value[0];
                        end
                    end
                    spg_pkg::KIND_ENABLE: begin
                        if (i_value[31:1] != '0) begin
                            n_err[a_idx] = spg_pkg::ERR_PARAM;
                            err          = spg_pkg::ERR_PARAM;
                        end else if (!i_value[0]) begin
                            n_enable[a_idx]  = 1'b0;
                            n_counter[a_idx] = '0;
                        end else begin
                            n_enable[a_idx] = 1'b1;
                        end
                    end
                    spg_pkg::KIND_MOVE: begin
                        n_err[a_idx] = spg_pkg::ERR_PARAM;
                        err          = spg_pkg::ERR_PARAM;
                    end
                    spg_pkg::KIND_STATUS: begin
                        err = r_err[a_idx];
                    end
                    default: ;
                endcase
            end
        end else if (i_cmd.div_apply) begin
            n_counter[a_idx] = '0;
            if (r_op_is_move) begin
                if (quotient == '0) begin
                    n_remain[a_idx] = '0;
                    n_enable[a_idx] = 1'b0;
                end else begin
                    n_remain[a_idx] = quotient[spg_pkg::PULSE_W-1:0];
                    n_enable[a_idx] = 1'b1;
                end
            end else begin
                n_reload[a_idx] = (quotient == '0) ? '0
                                                   : (quotient - spg_pkg::PERIOD_W'(1));
                n_half[a_idx]   = quotient >> 1;
                n_speed[a_idx]  = r_op_speed;
            end
        end

        for (int m = 0; m < MC; m++) begin
            lvl_all[m] = n_enable[m] && (n_speed[m] != '0) && (n_counter[m] < n_half[m]);
        end

        result.error = err;
        if (a_valid) begin
            result.enabled     = n_enable[a_idx];
            result.direction   = n_dir[a_idx];
            result.speed_now   = n_speed[a_idx];
            result.pulses_left = n_remain[a_idx];
            result.position    = $signed(n_pos[a_idx]);
        end else begin
            result.enabled     = 1'b0;
            result.direction   = 1'b0;
            result.speed_now   = '0;
            result.pulses_left = '0;
            result.position    = '0;
        end
        result.step_levels = spg_pkg::LANE_BITS'(lvl_all);
        result.finished    = spg_pkg::LANE_BITS'(fin_all);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter_freq <= spg_pkg::RST_COUNTER_FREQ;
            r_min_speed    <= spg_pkg::RST_MIN_SPEED;
            r_max_speed    <= spg_pkg::RST_MAX_SPEED;
            r_step_angle   <= spg_pkg::RST_STEP_ANGLE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                spg_pkg::REG_COUNTER_FREQ: r_counter_freq <= i_cfg_data;
                spg_pkg::REG_MIN_SPEED:    r_min_speed  <= i_cfg_data[spg_pkg::SPEED_W-1:0];
                spg_pkg::REG_MAX_SPEED:    r_max_speed  <= i_cfg_data[spg_pkg::SPEED_W-1:0];
                spg_pkg::REG_STEP_ANGLE:   r_step_angle <= i_cfg_data[spg_pkg::ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < MC; m++) begin
                r_enable[m]  <= 1'b0;
                r_dir[m]     <= 1'b0;
                r_speed[m]   <= '0;
                r_reload[m]  <= '0;
                r_half[m]    <= '0;
                r_counter[m] <= '0;
                r_remain[m]  <= '0;
                r_pos[m]     <= '0;
                r_err[m]     <= spg_pkg::ERR_OK;
            end
        end else begin
            r_enable  <= n_enable;
            r_dir     <= n_dir;
            r_speed   <= n_speed;
            r_reload  <= n_reload;
            r_half    <= n_half;
            r_counter <= n_counter;
            r_remain  <= n_remain;
            r_pos     <= n_pos;
            r_err     <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_op_is_move <= in_is_move;
            r_op_motor   <= i_motor;
            r_op_speed   <= i_value[spg_pkg::SPEED_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_out <= result;
        end
    end

    assign o_result = r_out;

endmodule

>>> design/stepper_pulse_generator_unit.sv
// Stepper pulse generator: step/direction state for several motors
//
// Usage: commands enter on i_in (kind, motor, value); every transfer yields
// exactly one result on o_out, in order. A tick advances the period counter
// of each enabled motor with nonzero speed by one counter clock. Registers
// must be written on i_cfg_* only while idle by the user; the block does
// not enforce it. Ticks, direction, enable, status, zero speed and every
// rejected command reach the output register in the cycle after their input
// transfer and run at one transfer per cycle unless the receiver stalls. An
// accepted speed (counter_freq/speed) or move (angle*100/step_angle) uses
// the shared 28-step restoring divider, and no new input is taken until its
// result is loaded. When the receiver stalls, the result holds in the output
// register; the next input is still taken if the receiver takes the pending
// result in the same cycle, otherwise input stalls as well.
// Reset (synchronous, active low) disables all motors, clears speeds,
// counters, positions and errors, and loads the register reset values.
module stepper_pulse_generator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    spg_in_if.sink                            i_in,
    spg_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [spg_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [spg_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    spg_pkg::t_ctrl_cmd    cmd;
    spg_pkg::t_ctrl_status status;
    spg_pkg::t_result      result;
    logic                  in_ready;
    logic                  out_valid;

    spg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    spg_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_kind      (i_in.kind),
        .i_motor     (i_in.motor),
        .i_value     (i_in.value),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_result    (result)
    );

    assign i_in.ready        = in_ready;
    assign o_out.valid       = out_valid;
    assign o_out.error       = result.error;
    assign o_out.enabled     = result.enabled;
    assign o_out.direction   = result.direction;
    assign o_out.speed_now   = result.speed_now;
    assign o_out.pulses_left = result.pulses_left;
    assign o_out.position    = result.position;
    assign o_out.step_levels = result.step_levels;
    assign o_out.finished    = result.finished;

endmodule
